### sv/cumulative_channel_mean_top_macros.svh
// assertion macros for the cumulative channel mean block
`ifndef CUMULATIVE_CHANNEL_MEAN_TOP_MACROS_SVH
`define CUMULATIVE_CHANNEL_MEAN_TOP_MACROS_SVH
`ifndef SYNTH
`define CCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccm check failed");
`define CCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccm check failed");
`else
`define CCM_ASSERT_IMPL(lbl, ante, cons)
`define CCM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/ccm_pkg.sv
// shared constants, types and codes for the cumulative channel mean block
package ccm_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH + 8;
  localparam int CFG_WIDTH    = 9;
  localparam int POS_WIDTH    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_MIN_W    = $clog2(MAX_CHANNELS + 1);
  localparam int NCH_WIDTH    = (CFG_WIDTH > NCH_MIN_W) ? CFG_WIDTH : NCH_MIN_W;
  localparam int QUOT_BITS    = SAMPLE_WIDTH + 1;
  localparam int MCNT_WIDTH   = $clog2(COUNT_WIDTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0]   SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### sv/ccm_channels.sv
// handshake channel interfaces for the cumulative channel mean block
interface ccm_in_if;
  import ccm_pkg::*;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [COUNT_WIDTH-1:0]         cache_length;
  modport source (output valid, operation, sample, cache_length, input ready);
  modport sink (input valid, operation, sample, cache_length, output ready);
endinterface

interface ccm_out_if;
  import ccm_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic [COUNT_WIDTH-1:0]         frames_seen;
  logic                           frame_end;
  modport source (output valid, mean, frames_seen, frame_end, input ready);
  modport sink (input valid, mean, frames_seen, frame_end, output ready);
endinterface

interface ccm_cfg_if;
  import ccm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_WIDTH-1:0] channel_count;
  modport source (output valid, channel_count, input ready);
  modport sink (input valid, channel_count, output ready);
endinterface

### sv/ccm_ram.sv
// generic single-write, single-read ram with registered read data
module ccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/ccm_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle
module ccm_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [ccm_pkg::SAMPLE_WIDTH-1:0] multiplicand,
  input  logic [ccm_pkg::COUNT_WIDTH-1:0]        multiplier,
  output logic signed [ccm_pkg::SUM_WIDTH-1:0]   product,
  output ccm_pkg::unit_stat_t                    stat
);
  import ccm_pkg::*;

  localparam logic [MCNT_WIDTH-1:0] CNT_LAST = MCNT_WIDTH'(COUNT_WIDTH - 1);

  logic                   busy;
  logic                   done;
  logic [MCNT_WIDTH-1:0]  cnt;
  logic [SUM_WIDTH-1:0]   acc;
  logic [SUM_WIDTH-1:0]   mcand;
  logic [COUNT_WIDTH-1:0] mplr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= {{(SUM_WIDTH-SAMPLE_WIDTH){multiplicand[SAMPLE_WIDTH-1]}}, multiplicand};
      mplr  <= multiplier;
    end else if (busy) begin
      if (mplr[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand << 1;
      mplr  <= mplr >> 1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

### sv/ccm_div.sv
// restoring divider, one quotient bit per cycle, saturating signed result
module ccm_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [ccm_pkg::SUM_WIDTH-1:0]   dividend,
  input  logic [ccm_pkg::COUNT_WIDTH-1:0]        divisor,
  output logic signed [ccm_pkg::SAMPLE_WIDTH-1:0] quotient,
  output ccm_pkg::unit_stat_t                    stat
);
  import ccm_pkg::*;

  localparam int HI_WIDTH   = SUM_WIDTH - QUOT_BITS;
  localparam int STEP_WIDTH = $clog2(QUOT_BITS + 2);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(QUOT_BITS + 1);
  localparam logic [QUOT_BITS-1:0]  Q_HALF    = QUOT_BITS'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [SAMPLE_WIDTH-1:0] Q_MAX   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] Q_MIN   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                    busy;
  logic                    done;
  logic [STEP_WIDTH-1:0]   step;
  logic                    neg;
  logic                    ovf;
  logic [SUM_WIDTH-1:0]    mag;
  logic [COUNT_WIDTH-1:0]  dvs;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [QUOT_BITS-1:0]    shreg;
  logic [COUNT_WIDTH:0]    partial;
  logic                    ge;
  logic [COUNT_WIDTH:0]    diff;
  logic [SAMPLE_WIDTH-1:0] sat_q;

  // trial subtract of the shifted partial remainder
  assign partial = {rem, shreg[QUOT_BITS-1]};
  assign ge      = partial >= {1'b0, dvs};
  assign diff    = partial - {1'b0, dvs};

  always_comb begin
    if (ovf) begin
      sat_q = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      sat_q = (shreg > Q_HALF) ? Q_MIN : (~shreg[SAMPLE_WIDTH-1:0] + 1'b1);
    end else begin
      sat_q = (shreg >= Q_HALF) ? Q_MAX : shreg[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_WIDTH-1];
      mag <= dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (step == '0) begin
        // quotient of 2^QUOT_BITS or more cannot fit the result
        ovf   <= mag[SUM_WIDTH-1:QUOT_BITS] >= {{(HI_WIDTH-COUNT_WIDTH){1'b0}}, dvs};
        rem   <= mag[QUOT_BITS+COUNT_WIDTH-1:QUOT_BITS];
        shreg <= mag[QUOT_BITS-1:0];
      end else if (step != STEP_LAST) begin
        rem   <= ge ? diff[COUNT_WIDTH-1:0] : partial[COUNT_WIDTH-1:0];
        shreg <= {shreg[QUOT_BITS-2:0], ge};
      end else begin
        quotient <= sat_q;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

### sv/cumulative_channel_mean_top.sv
// top level of the per-channel cumulative mean block
//
//   channel  | role   | moves per transfer
//   ---------+--------+--------------------------------------------
//   cfg_ch   | sink   | channel_count (channels per frame)
//   in_ch    | sink   | operation, sample, cache_length
//   out_ch   | source | mean, frames_seen, frame_end
//
// one item at a time: no new transfer is taken until the last item's result is in the
// output register; a sample waits on the bit-serial divider (one quotient bit a cycle)
// and a load on the shift-add multiplier
// reset is synchronous and clears a valid flag per channel, so unwritten sums read as zero
// a stalled output holds its result; the block finishes the next item and
// waits with it until the output register is free
`include "cumulative_channel_mean_top_macros.svh"

module cumulative_channel_mean_top (
  input  logic      clk,
  input  logic      rst,
  ccm_cfg_if.sink   cfg_ch,
  ccm_in_if.sink    in_ch,
  ccm_out_if.source out_ch
);
  import ccm_pkg::*;

  // control state
  state_t                 state;
  state_t                 state_next;
  logic [CFG_WIDTH-1:0]   channel_count;
  logic [POS_WIDTH-1:0]   pos;
  logic [COUNT_WIDTH-1:0] frame_counter;
  logic [MAX_CHANNELS-1:0] sum_valid;
  logic                   out_valid;

  // item held while it is worked on
  logic                          op_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COUNT_WIDTH-1:0]        len_q;
  logic [POS_WIDTH-1:0]          acc_pos;
  logic [COUNT_WIDTH-1:0]        d_q;
  logic                          last_q;
  logic signed [SUM_WIDTH-1:0]   sum_q;

  // result register
  logic signed [SAMPLE_WIDTH-1:0] out_mean;
  logic [COUNT_WIDTH-1:0]         out_frames;
  logic                           out_end;

  // decoded controls
  logic accept;
  logic in_ready;
  logic mul_start;
  logic div_start;
  logic ram_we;
  logic load_out;
  logic out_free;

  // channel position and divisor for the item on offer
  logic [NCH_WIDTH-1:0]   cnt_ext;
  logic [NCH_WIDTH-1:0]   nch;
  logic [NCH_WIDTH-1:0]   pos_ext;
  logic [NCH_WIDTH-1:0]   pos_eff;
  logic                   acc_last;
  logic [COUNT_WIDTH:0]   fc_plus;
  logic [COUNT_WIDTH-1:0] d_next;

  // sum datapath
  logic [SUM_WIDTH-1:0]          rdata;
  logic [SUM_WIDTH-1:0]          wdata;
  logic signed [SUM_WIDTH-1:0]   sum_old;
  logic [SUM_WIDTH:0]            sum_ext;
  logic [SUM_WIDTH-1:0]          sum_sat;
  logic signed [SUM_WIDTH-1:0]   product;
  logic signed [SAMPLE_WIDTH-1:0] quotient;
  unit_stat_t                    mul_stat;
  unit_stat_t                    div_stat;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;

  // zero channels acts as one, too many is capped
  assign cnt_ext = NCH_WIDTH'(channel_count);
  always_comb begin
    if (cnt_ext == '0) begin
      nch = NCH_WIDTH'(1);
    end else if (cnt_ext > NCH_WIDTH'(MAX_CHANNELS)) begin
      nch = NCH_WIDTH'(MAX_CHANNELS);
    end else begin
      nch = cnt_ext;
    end
  end

  // a position left beyond a lowered count is taken as the frame's last channel
  assign pos_ext  = NCH_WIDTH'(pos);
  assign pos_eff  = (pos_ext >= nch) ? (nch - 1'b1) : pos_ext;
  assign acc_last = pos_eff == (nch - 1'b1);

  // divisor is frames so far plus one, saturating
  assign fc_plus = {1'b0, frame_counter} + 1'b1;
  assign d_next  = fc_plus[COUNT_WIDTH] ? COUNT_MAX : fc_plus[COUNT_WIDTH-1:0];

  // unwritten channels read as zero
  assign sum_old = sum_valid[acc_pos] ? rdata : '0;
  assign sum_ext = {sum_old[SUM_WIDTH-1], sum_old}
                 + {{(SUM_WIDTH+1-SAMPLE_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q};
  always_comb begin
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  assign wdata = (state == ST_WR) ? sum_q : product;

  ccm_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (MAX_CHANNELS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (acc_pos),
    .wdata (wdata),
    .raddr (pos_eff[POS_WIDTH-1:0]),
    .rdata (rdata)
  );

  ccm_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (sample_q),
    .multiplier   (len_q),
    .product      (product),
    .stat         (mul_stat)
  );

  ccm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_q),
    .divisor  (d_q),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = (op_q == OP_LOAD) ? ST_MUL : ST_WR;
      end
      ST_WR: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // decoded controls per state
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_RD:   mul_start = op_q == OP_LOAD;
      ST_WR: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_MUL:  ram_we    = mul_stat.done;
      ST_FIN:  load_out  = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      channel_count <= CFG_WIDTH'(1);
      pos           <= '0;
      frame_counter <= '0;
      sum_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_ch.valid) begin
        channel_count <= cfg_ch.channel_count;
      end
      if (accept) begin
        if (in_ch.operation == OP_LOAD) begin
          // a load sets the count and leaves the position alone
          frame_counter <= in_ch.cache_length;
        end else if (acc_last) begin
          pos <= '0;
          if (frame_counter != COUNT_MAX) begin
            frame_counter <= frame_counter + 1'b1;
          end
        end else begin
          pos <= pos_eff[POS_WIDTH-1:0] + 1'b1;
        end
      end
      if (ram_we) begin
        sum_valid[acc_pos] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= in_ch.operation;
      sample_q <= in_ch.sample;
      len_q    <= in_ch.cache_length;
      acc_pos  <= pos_eff[POS_WIDTH-1:0];
      d_q      <= d_next;
      last_q   <= acc_last;
    end
    if (state == ST_RD) begin
      sum_q <= sum_sat;
    end
    if (load_out) begin
      if (op_q == OP_LOAD) begin
        out_mean   <= sample_q;
        out_frames <= len_q;
        out_end    <= 1'b0;
      end else begin
        out_mean   <= quotient;
        out_frames <= d_q;
        out_end    <= last_q;
      end
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.mean        = out_mean;
  assign out_ch.frames_seen = out_frames;
  assign out_ch.frame_end   = out_end;

  // ram is written only when a new sum is ready
  `CCM_ASSERT_IMPL(a_we_state, ram_we, (state == ST_WR) || (state == ST_MUL))
  // the two serial units never run together
  `CCM_ASSERT_IMPL(a_units_excl, mul_stat.busy, !div_stat.busy)
  // a finished division is only seen while waiting for it
  `CCM_ASSERT_IMPL(a_div_done, div_stat.done, state == ST_DIV)
  // the last channel of a frame advances a non-saturated frame count by one
  `CCM_ASSERT_NEXT(a_fc_step,
                   accept && (in_ch.operation == OP_SAMPLE) && acc_last
                     && (frame_counter != COUNT_MAX),
                   frame_counter == $past(frame_counter) + 1'b1)

endmodule

### dv/testbench.sv
// self-checking testbench for the per-channel cumulative mean block
module testbench;
  import ccm_pkg::*;

  localparam int ITEM_LATENCY = 24;
  localparam int RANDOM_ITEMS = 750;
  localparam int MISMATCH_SHOWN = 10;
  // generous ceiling, several times the slowest legal run
  localparam int RUN_CEILING = 3_000_000;

  localparam int unsigned TALLY_TOP = (1 << COUNT_WIDTH) - 1;
  localparam longint SUM_TOP = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_BOTTOM = -SUM_TOP - 1;
  localparam longint MEAN_TOP = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint MEAN_BOTTOM = -MEAN_TOP - 1;

  // what the output channel should carry for one input transfer
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] mean;
    logic [COUNT_WIDTH-1:0]  frames_seen;
    logic                    frame_end;
  } mean_result_t;

  // receiver behaviour, picked at random by the result sink
  typedef enum int {
    SINK_OPEN,
    SINK_JITTER,
    SINK_SPARSE
  } sink_mode_t;

  logic clk;
  logic rst;

  ccm_cfg_if cfg_ch ();
  ccm_in_if  in_ch ();
  ccm_out_if out_ch ();

  cumulative_channel_mean_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // running-mean predictor state, mirrors the block after reset
  longint       channel_sum [MAX_CHANNELS];
  int unsigned  frame_tally;
  int unsigned  chan_pos;
  int unsigned  chan_cfg;

  // results still owed by the block, oldest first
  mean_result_t pending_means [$];
  int           mismatch_count = 0;

  // sender burst bookkeeping and the long receiver hold-off
  int           burst_left = 0;
  bit           sender_gapless = 1'b0;
  int           hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_CEILING;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advances the predictor by one accepted transfer and returns its result
  function automatic mean_result_t compute_running_mean(op_t op,
                                                        logic signed [SAMPLE_WIDTH-1:0] smp,
                                                        logic [COUNT_WIDTH-1:0] len);
    mean_result_t r;
    int unsigned  nch;
    int unsigned  pos;
    int unsigned  divisor;
    longint       s;
    longint       q;
    // a zero count acts as one, anything above the ram depth as the full depth
    nch = (chan_cfg == 0) ? 1 : ((chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg);
    // count lowered mid-frame: the item lands on the last channel in use
    pos = (chan_pos >= nch) ? nch - 1 : chan_pos;
    s = smp;
    if (op == OP_LOAD) begin
      // seed the channel from the cached average, position stays put
      channel_sum[pos] = clamp_to(s * longint'(len), SUM_BOTTOM, SUM_TOP);
      frame_tally = len;
      r.mean = smp;
      r.frames_seen = len;
      r.frame_end = 1'b0;
    end else begin
      divisor = frame_tally + 1;
      if (divisor > TALLY_TOP) divisor = TALLY_TOP;
      channel_sum[pos] = clamp_to(channel_sum[pos] + s, SUM_BOTTOM, SUM_TOP);
      q = clamp_to(channel_sum[pos] / longint'(divisor), MEAN_BOTTOM, MEAN_TOP);
      r.mean = SAMPLE_WIDTH'(q);
      r.frames_seen = COUNT_WIDTH'(divisor);
      r.frame_end = (pos == nch - 1);
      if (pos == nch - 1) begin
        chan_pos = 0;
        if (frame_tally < TALLY_TOP) frame_tally++;
      end else begin
        chan_pos = pos + 1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] random_length();
    case ($urandom_range(0, 9))
      0, 1: return COUNT_WIDTH'($urandom_range(0, 10));
      2: return '1;
      3, 4: return COUNT_WIDTH'($urandom_range(0, 1000));
      default: return COUNT_WIDTH'($urandom);
    endcase
  endfunction

  // offers one item, in bursts with random gaps, and books its result on transfer
  task automatic send_item(op_t op, logic signed [SAMPLE_WIDTH-1:0] smp,
                           logic [COUNT_WIDTH-1:0] len);
    int gap;
    if (!sender_gapless && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.sample = smp;
    in_ch.cache_length = len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_means.push_back(compute_running_mean(op, smp, len));
    @(negedge clk);
  endtask

  // stops offering and waits until every owed result has come out
  task automatic wait_for_drain();
    in_ch.valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
  endtask

  // the register is only written with the block idle
  task automatic write_channel_count(logic [CFG_WIDTH-1:0] value);
    wait_for_drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.channel_count = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    chan_cfg = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // reset default of one channel: sample extremes, every sample ends a frame
  task automatic test_single_channel_extremes();
    send_item(OP_SAMPLE, 16'sh7fff, '0);
    send_item(OP_SAMPLE, 16'sh8000, '1);
    send_item(OP_SAMPLE, -16'sd1, '0);
    send_item(OP_LOAD, 16'sh8000, '0);
  endtask

  // zero and oversized counts, then a count lowered below the current position
  task automatic test_channel_count_limits();
    write_channel_count('0);
    send_item(OP_SAMPLE, 16'sd256, '0);
    send_item(OP_SAMPLE, -16'sd256, '0);
    write_channel_count('1);
    send_item(OP_SAMPLE, 16'sd5, '0);
    send_item(OP_SAMPLE, 16'sd7, '0);
    write_channel_count(CFG_WIDTH'(MAX_CHANNELS));
    send_item(OP_SAMPLE, 16'sd9, '0);
    // position now three, count two: the load hits the last channel and leaves position alone
    write_channel_count(CFG_WIDTH'(2));
    send_item(OP_LOAD, 16'sd1000, 16'd3);
    send_item(OP_SAMPLE, 16'sd11, '0);
  endtask

  // divisor pinned at the counter maximum, also reached by counting
  task automatic test_divisor_saturation();
    write_channel_count(CFG_WIDTH'(1));
    send_item(OP_LOAD, 16'sd100, 16'hfffe);
    send_item(OP_SAMPLE, 16'sd200, '0);
    send_item(OP_SAMPLE, -16'sd300, '0);
    send_item(OP_LOAD, 16'sd5, '1);
    send_item(OP_SAMPLE, 16'sd0, '0);
  endtask

  // a channel seeded large, then the shared counter knocked back by a load elsewhere
  task automatic test_mean_saturation();
    write_channel_count(CFG_WIDTH'(2));
    send_item(OP_LOAD, 16'sh7fff, 16'd60000);
    send_item(OP_SAMPLE, 16'sh7fff, '0);
    send_item(OP_LOAD, 16'sd0, 16'd0);
    send_item(OP_SAMPLE, 16'sd0, '0);
    send_item(OP_SAMPLE, 16'sd0, '0);
    // same again towards the negative limit with the channels swapped
    send_item(OP_LOAD, 16'sh8000, 16'd60000);
    send_item(OP_SAMPLE, 16'sh8000, '0);
    send_item(OP_LOAD, 16'sd0, 16'd0);
    send_item(OP_SAMPLE, 16'sd0, '0);
    send_item(OP_SAMPLE, 16'sd0, '0);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    int i;
    write_channel_count(CFG_WIDTH'(4));
    hold_left = 40 * ITEM_LATENCY;
    sender_gapless = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_item(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_SAMPLE,
                random_sample(), random_length());
    end
    sender_gapless = 1'b0;
  endtask

  // phases of items at random channel counts, an occasional load between
  task automatic test_random_frames();
    int                   sent;
    int                   span;
    int                   i;
    int                   pick;
    logic [CFG_WIDTH-1:0] chan_total;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) chan_total = CFG_WIDTH'($urandom_range(1, 8));
      else if (pick < 16) chan_total = CFG_WIDTH'($urandom_range(9, 40));
      else if (pick < 18) chan_total = '0;
      else if (pick < 19) chan_total = CFG_WIDTH'(MAX_CHANNELS);
      else chan_total = CFG_WIDTH'($urandom_range(MAX_CHANNELS + 1, 511));
      // full-depth phases run just past one frame, the rest for 30 to 80 items
      span = (chan_total > 40) ? MAX_CHANNELS + $urandom_range(1, 24)
                               : $urandom_range(30, 80);
      write_channel_count(chan_total);
      for (i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 15) == 0) send_item(OP_LOAD, random_sample(), random_length());
        else send_item(OP_SAMPLE, random_sample(), COUNT_WIDTH'($urandom));
        sent++;
      end
    end
  endtask

  // receiver: long hold-off first when asked for, else a stall pattern of its own
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         tick;
    mode = SINK_OPEN;
    mode_left = 0;
    tick = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(40, 160);
        end
        mode_left--;
        tick++;
        case (mode)
          SINK_OPEN: out_ch.ready = 1'b1;
          SINK_JITTER: out_ch.ready = ($urandom_range(0, 9) < 6);
          default: out_ch.ready = (tick % 5 == 0);
        endcase
      end
    end
  end

  // every output transfer is matched against the oldest owed result
  always @(posedge clk) begin : result_check
    mean_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_means.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN)
          $display("unexpected result: mean %0d frames_seen %0d frame_end %0b",
                   $signed(out_ch.mean), out_ch.frames_seen, out_ch.frame_end);
      end else begin
        want = pending_means.pop_front();
        if (out_ch.mean !== want.mean || out_ch.frames_seen !== want.frames_seen ||
            out_ch.frame_end !== want.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOWN)
            $display("result mismatch: mean exp %0d got %0d, frames_seen exp %0d got %0d, %s",
                     $signed(want.mean), $signed(out_ch.mean), want.frames_seen,
                     out_ch.frames_seen,
                     $sformatf("frame_end exp %0b got %0b", want.frame_end, out_ch.frame_end));
        end
      end
    end
  end

  initial begin : run_tests
    int i;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SAMPLE;
    in_ch.sample = '0;
    in_ch.cache_length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.channel_count = CFG_WIDTH'(1);
    for (i = 0; i < MAX_CHANNELS; i++) channel_sum[i] = 0;
    frame_tally = 0;
    chan_pos = 0;
    chan_cfg = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_channel_extremes();
    test_channel_count_limits();
    test_divisor_saturation();
    test_mean_saturation();
    test_output_backpressure();
    test_random_frames();

    // let any stray late result show up before judging
    wait_for_drain();
    repeat (2 * ITEM_LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
